>>> src/bfm_pkg.sv
// shared types and constants for the bfloat16 truncating multiplier
package bfm_pkg;
   localparam int unsigned WordWidth = 16;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned FracWidth = 7;
   localparam int unsigned SigWidth  = FracWidth + 1;
   localparam int unsigned ProdWidth = 2 * SigWidth;
   localparam logic [ExpWidth-1:0] ExpMax  = 8'hFF;
   localparam logic [9:0]          ExpBias = 10'd127;
   localparam logic [WordWidth-2:0] MaxFinite = 15'h7F7F;

   // partial state handed from cell to cell
   typedef struct packed {
      logic                 sign;
      logic                 zero;
      logic [9:0]           exp_sum;
      logic [SigWidth-1:0]  sig_a;
      logic [SigWidth-1:0]  sig_b;
      logic [ProdWidth-1:0] acc;
   } stage_type;
endpackage

>>> src/bfm_stream_if.sv
// valid/ready channel carrying a word
interface bfm_stream_if #(parameter int unsigned Width = 16);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/bfm_cell.sv
// one shift-add cell: adds one partial product row, passes state on
module bfm_cell
   import bfm_pkg::*;
#(
   parameter int unsigned BitIndex = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  stage_type stage_in,
   output logic      valid_out,
   output stage_type stage_out
);
   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in_w;

   // add operand a shifted by this bit of operand b
   always_comb begin
      stage_in_w = stage_in;
      if (stage_in.sig_b[BitIndex])
         stage_in_w.acc = stage_in.acc
                        + (ProdWidth'(stage_in.sig_a) << BitIndex);
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (advance)
         valid_ff <= valid_in;
      if (advance)
         stage_ff <= stage_in_w;
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;
endmodule

>>> src/bf16_multiplier_truncating_ftz_unit.sv
// top level: bfloat16 multiplier, truncating, flush to zero, saturating
//  channel | dir | word
//  req     | in  | operand_a, operand_b (16 bits each)
//  rsp     | out | product (16 bits)
// one word accepted per cycle while the chain advances; stages are the decode register, eight
// shift-add cells, one per significand bit, then the output register
// the whole chain advances when the output register is empty or being taken
// synchronous reset clears all valid bits; payload is not reset
module bf16_multiplier_truncating_ftz_unit
   import bfm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [WordWidth-1:0] req_operand_a,
   input  logic [WordWidth-1:0] req_operand_b,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [WordWidth-1:0] rsp_product
);
   logic      advance;
   logic      valid_chain [SigWidth+1];
   stage_type stage_chain [SigWidth+1];
   logic      dec_valid_ff;
   stage_type dec_ff, dec_in;
   logic      out_valid_ff;
   logic [WordWidth-1:0] out_ff, out_in;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // operand cleanup and exponent sum
   always_comb begin
      logic [ExpWidth-1:0] ea, eb;
      logic sa, sb;
      ea = req_operand_a[WordWidth-2:FracWidth];
      eb = req_operand_b[WordWidth-2:FracWidth];
      sa = req_operand_a[WordWidth-1] && ea != ExpMax;
      sb = req_operand_b[WordWidth-1] && eb != ExpMax;
      dec_in.sign    = sa ^ sb;
      dec_in.zero    = ea == '0 || eb == '0 || ea == ExpMax || eb == ExpMax;
      dec_in.exp_sum = 10'(ea) + 10'(eb);
      dec_in.sig_a   = {1'b1, req_operand_a[FracWidth-1:0]};
      dec_in.sig_b   = {1'b1, req_operand_b[FracWidth-1:0]};
      dec_in.acc     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         dec_valid_ff <= 1'b0;
      else if (advance)
         dec_valid_ff <= req_valid;
      if (advance)
         dec_ff <= dec_in;
   end

   assign valid_chain[0] = dec_valid_ff;
   assign stage_chain[0] = dec_ff;

   // row of shift-add cells
   for (genvar i = 0; i < SigWidth; i++) begin : g_cell
      bfm_cell #(.BitIndex(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .valid_in (valid_chain[i]),
         .stage_in (stage_chain[i]),
         .valid_out(valid_chain[i+1]),
         .stage_out(stage_chain[i+1])
      );
   end

   // normalize, truncate, saturate, flush
   always_comb begin
      stage_type s;
      logic [9:0] ex;
      logic [FracWidth-1:0] frac;
      s  = stage_chain[SigWidth];
      ex = s.exp_sum - ExpBias + 10'(s.acc[ProdWidth-1]);
      frac = s.acc[ProdWidth-1] ? s.acc[ProdWidth-2:SigWidth]
                                : s.acc[ProdWidth-3:FracWidth];
      if (s.zero)
         out_in = {s.sign, 15'd0};
      else if (ex[9] || ex == '0)
         out_in = {s.sign, 15'd0};
      else if (ex >= 10'd255)
         out_in = {s.sign, MaxFinite};
      else
         out_in = {s.sign, ex[ExpWidth-1:0], frac};
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (advance)
         out_valid_ff <= valid_chain[SigWidth];
      if (advance)
         out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_product = out_ff;
endmodule

>>> tb/sv/bf16_multiplier_truncating_ftz_unit_test.sv
// self-checking testbench for the bfloat16 truncating flush-to-zero multiplier
module bf16_multiplier_truncating_ftz_unit_test;
   import bfm_pkg::*;

   localparam int unsigned RandomWords = 1850;
   localparam int unsigned DrainCycles = 20;
   localparam logic [15:0] SignMask    = 16'h8000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bfm_stream_if #(.Width(2 * WordWidth)) req_if ();
   bfm_stream_if #(.Width(WordWidth))     rsp_if ();

   logic [2*WordWidth-1:0] pending_words[$];
   logic [WordWidth-1:0]   expected_products[$];
   int unsigned error_count = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_gap = 0;
   bit          req_taken = 1'b0;
   bit          stim_done = 1'b0;

   initial begin
      req_if.valid  = 1'b0;
      req_if.data   = '0;
      rsp_if.ready  = 1'b0;
   end

   bf16_multiplier_truncating_ftz_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_operand_a (req_if.data[2*WordWidth-1:WordWidth]),
      .req_operand_b (req_if.data[WordWidth-1:0]),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_product   (rsp_if.data)
   );

   always #5 clock = ~clock;

   // operand cleanup: subnormal keeps sign as zero, inf or nan becomes +0
   function automatic logic [15:0] clean_operand(input logic [15:0] v);
      if (v[14:7] == ExpMax) return 16'h0000;
      if (v[14:7] == 8'h00)  return v & SignMask;
      return v;
   endfunction

   // truncating product with saturation and flush to zero
   function automatic logic [15:0] bf16_product(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] ca, cb, sign;
      logic [15:0] sig_prod;
      logic [6:0]  frac;
      int          ex;
      ca   = clean_operand(a);
      cb   = clean_operand(b);
      sign = (ca ^ cb) & SignMask;
      if (ca[14:7] == 8'h00 || cb[14:7] == 8'h00) return sign;
      sig_prod = {8'h00, 1'b1, ca[6:0]} * {8'h00, 1'b1, cb[6:0]};
      ex = int'(ca[14:7]) + int'(cb[14:7]) - 127;
      if (sig_prod[15]) begin
         ex   = ex + 1;
         frac = sig_prod[14:8];
      end else begin
         frac = sig_prod[13:7];
      end
      if (ex >= 255) return sign | {1'b0, MaxFinite};
      if (ex <= 0)   return sign;
      return sign | {1'b0, ex[7:0], frac};
   endfunction

   // random operand, biased toward the interesting exponents
   function automatic logic [15:0] random_operand();
      logic [7:0] ex;
      case ($urandom_range(0, 11))
         0:       ex = 8'h00;
         1:       ex = ExpMax;
         2:       ex = 8'($urandom_range(1, 4));
         3:       ex = 8'($urandom_range(251, 254));
         4, 5:    ex = 8'($urandom_range(55, 70));
         6, 7:    ex = 8'($urandom_range(185, 200));
         8:       ex = 8'($urandom_range(0, 255));
         default: ex = 8'($urandom_range(100, 154));
      endcase
      return {1'($urandom_range(0, 1)), ex, 7'($urandom_range(0, 127))};
   endfunction

   function automatic int unsigned random_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0)  return 0;
      return $urandom_range(0, 2);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // stimulus: directed corners then random words
   initial begin
      logic [15:0] corner[$];
      corner = '{16'h0000, 16'h8000, 16'h0001, 16'h807F, 16'h7F80, 16'hFF80,
                 16'h7FC1, 16'hFFFF, 16'h3F80, 16'hBF80, 16'h3FC0, 16'h7F7F,
                 16'hFF7F, 16'h0080, 16'h8080, 16'h3FFF};
      foreach (corner[i]) pending_words.push_back({corner[i], corner[(i * 5 + 3) % 16]});
      pending_words.push_back({16'h3FC0, 16'h3FC0});  // carry out of the significand
      pending_words.push_back({16'h7F00, 16'h4000});  // exponent lands on 255
      pending_words.push_back({16'h7F7F, 16'h7F7F});  // deep overflow
      pending_words.push_back({16'h2000, 16'h1F80});  // exponent lands on 0
      pending_words.push_back({16'h2000, 16'h2000});  // exponent lands on 1
      pending_words.push_back({16'h0080, 16'h0080});  // deep underflow
      pending_words.push_back({16'h8000, 16'hFF80});  // negative zero times inf
      pending_words.push_back({16'hC2F7, 16'h0000});
      for (int i = 0; i < RandomWords; i++)
         pending_words.push_back({random_operand(), random_operand()});
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: new word or gap at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_if.valid && !req_taken) begin
            req_if.valid <= 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_if.data  <= pending_words.pop_front();
            req_if.valid <= 1'b1;
            req_gap = random_gap();
         end else begin
            req_if.valid <= 1'b0;
            stim_done = 1'b1;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_gap = random_gap();
         end
      end
   end

   // monitor: record accepted words, check accepted products
   always @(posedge clock) begin
      logic [15:0] want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            expected_products.push_back(bf16_product(req_if.data[31:16], req_if.data[15:0]));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_products.size() == 0) begin
               report_mismatch("unexpected word", rsp_if.data, 16'h0000);
            end else begin
               want = expected_products.pop_front();
               if (rsp_if.data !== want) report_mismatch("product", rsp_if.data, want);
            end
         end
      end
   end

   // end of run once everything has drained
   initial begin
      wait (stim_done && !req_if.valid);
      wait (expected_products.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (expected_products.size() != 0)
         report_mismatch("words left over", 16'h0000, 16'h0000);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
